// ----- design/sensor_sample_supervisor_macros.svh -----
// assertion macros shared by the supervisor checker
// needs nothing else; take it in with a plain include
`ifndef SENSOR_SAMPLE_SUPERVISOR_MACROS_SVH
`define SENSOR_SAMPLE_SUPERVISOR_MACROS_SVH

// same-cycle implication, off while in reset
`define SSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sensor sample supervisor check failed");

// next-cycle implication, off while in reset
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sensor sample supervisor check failed");

`endif

// ----- design/sss_pkg.sv -----
// types, codes and helpers of the sensor sample supervisor
// used by the channel interfaces, the top level and its checker
`timescale 1ns / 1ps

package sss_pkg;

	localparam int COUNT_WIDTH     = 16;
	localparam int SEQ_WIDTH       = 32;
	localparam int CFG_WIDTH       = 16;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_WIDTH-1:0] SAMPLE_PERIOD_RESET   = CFG_WIDTH'(100);
	localparam logic [CFG_WIDTH-1:0] PENDING_TIMEOUT_RESET = CFG_WIDTH'(10);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_SAMPLE_PERIOD   = 1'b0,
		CFG_PENDING_TIMEOUT = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		STATUS_IDLE           = 3'd0,
		STATUS_PENDING        = 3'd1,
		STATUS_PROCESSED      = 3'd2,
		STATUS_TIMEOUT        = 3'd3,
		STATUS_READ_FAILED    = 3'd4,
		STATUS_REQUEST_FAILED = 3'd5
	} status_code_t;

	typedef enum logic [1:0] {
		PORT_OK        = 2'd0,
		PORT_BUSY      = 2'd1,
		PORT_NOT_READY = 2'd2,
		PORT_ERROR     = 2'd3
	} port_result_t;

	typedef enum logic [1:0] {
		EVENT_NONE         = 2'd0,
		EVENT_SAMPLE       = 2'd1,
		EVENT_TIMEOUT      = 2'd2,
		EVENT_PORT_FAILURE = 2'd3
	} event_t;

	// raw status bit positions
	localparam int STAT_OVERRUN = 5;
	localparam int STAT_UNKNOWN = 6;
	// domain flag positions
	localparam int FLAG_VALID = 0;
	localparam int FLAG_STALE = 1;
	localparam int FLAG_FAULT = 4;

	typedef struct packed {
		logic [1:0]         request_result;
		logic [1:0]         read_result;
		logic [6:0]         sample_status;
		logic [6:0]         port_status;
		logic [31:0]        sample_sequence;
		logic signed [15:0] sample_temperature;
	} sample_word_t;

	typedef struct packed {
		logic [2:0]         status_code;
		logic               observation_valid;
		logic [31:0]        observation_number;
		logic signed [15:0] observed_temperature;
		logic [4:0]         domain_flags;
		logic [1:0]         obs_cause;
		logic               request_pending;
		logic [15:0]        pending_ticks;
		logic [31:0]        source_sequence_out;
		logic               from_sample;
		logic               source_stale;
		logic [1:0]         last_port_result;
	} result_word_t;

	// overrun means stale and fault, unknown means fault
	function automatic logic [4:0] map_status(input logic [6:0] s);
		logic [4:0] m;
		m = s[4:0];
		if (s[STAT_OVERRUN]) begin
			m[FLAG_STALE] = 1'b1;
			m[FLAG_FAULT] = 1'b1;
		end
		if (s[STAT_UNKNOWN]) begin
			m[FLAG_FAULT] = 1'b1;
		end
		return m;
	endfunction

endpackage

// ----- design/sss_channels.sv -----
// valid/ready channel interfaces for sample words in and result words out
// payload types come from sss_pkg
`timescale 1ns / 1ps

interface sss_in_if;
	logic                 valid;
	logic                 ready;
	sss_pkg::sample_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

interface sss_out_if;
	logic                 valid;
	logic                 ready;
	sss_pkg::result_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

// ----- design/sensor_sample_supervisor.sv -----
// latency: a result word is valid the cycle after its sample word is taken
// throughput: one word per cycle; the output register is refilled on the same
// edge that it empties, so only a stalled, full output register holds off input
// reset: period 100, timeout 10, nothing pending, first word requests at once,
// held observation fields and counters all zero
// depends on sss_pkg and the channel interfaces in sss_channels.sv
`timescale 1ns / 1ps

module sensor_sample_supervisor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [sss_pkg::CFG_WIDTH-1:0]        cfg_data,
	sss_in_if.sink                               sample_in,
	sss_out_if.source                            result_out
);

	localparam int CW = sss_pkg::COUNT_WIDTH;
	localparam int SW = sss_pkg::SEQ_WIDTH;

	logic [sss_pkg::CFG_WIDTH-1:0] period_cfg_q;
	logic [sss_pkg::CFG_WIDTH-1:0] timeout_cfg_q;

	logic               pending_q,    pending_n;
	logic [CW-1:0]      pend_cnt_q,   pend_cnt_n;
	logic [CW-1:0]      countdown_q,  countdown_n;
	logic               have_seq_q,   have_seq_n;
	logic [SW-1:0]      last_seq_q,   last_seq_n;
	logic [31:0]        obs_cnt_q,    obs_cnt_n;
	logic [31:0]        held_num_q,   held_num_n;
	logic signed [15:0] held_temp_q,  held_temp_n;
	logic [4:0]         held_flags_q, held_flags_n;
	logic [1:0]         held_event_q, held_event_n;
	logic [31:0]        held_seq_q,   held_seq_n;
	logic               held_has_q,   held_has_n;
	logic               held_stale_q, held_stale_n;
	logic [1:0]         held_port_q,  held_port_n;

	logic                  out_valid_q;
	sss_pkg::result_word_t out_q;
	sss_pkg::result_word_t result;

	sss_pkg::sample_word_t d;
	logic                  take;
	logic [SW-1:0]         seq_in;
	logic [SW-1:0]         seq_diff;
	logic                  seq_stale;
	logic [4:0]            fail_flags;
	logic [CW-1:0]         cnt_inc;
	logic [CW-1:0]         countdown_dec;
	logic                  request;
	logic                  do_obs;
	logic                  do_fail;
	logic signed [15:0]    obs_temp;
	logic [4:0]            obs_flags;
	logic [1:0]            obs_event;
	logic [2:0]            status;

	assign sample_in.ready  = !out_valid_q || result_out.ready;
	assign take             = sample_in.valid && sample_in.ready;
	assign result_out.valid = out_valid_q;
	assign result_out.payload = out_q;

	always_comb begin
		d        = sample_in.payload;
		seq_in   = d.sample_sequence[SW-1:0];
		seq_diff = seq_in - last_seq_q;
		// not strictly forward: equal, or forward distance of half the range or more
		seq_stale = have_seq_q && ((seq_diff == '0) || seq_diff[SW-1]);
		fail_flags = sss_pkg::map_status(d.port_status);
		fail_flags[sss_pkg::FLAG_VALID] = 1'b0;
		fail_flags[sss_pkg::FLAG_STALE] = 1'b1;
		fail_flags[sss_pkg::FLAG_FAULT] = 1'b1;
		cnt_inc       = (pend_cnt_q == '1) ? pend_cnt_q : pend_cnt_q + 1'b1;
		countdown_dec = countdown_q - 1'b1;
		request       = (countdown_q == '0) || (countdown_dec == '0);

		pending_n    = pending_q;
		pend_cnt_n   = pend_cnt_q;
		countdown_n  = countdown_q;
		have_seq_n   = have_seq_q;
		last_seq_n   = last_seq_q;
		obs_cnt_n    = obs_cnt_q;
		held_num_n   = held_num_q;
		held_temp_n  = held_temp_q;
		held_flags_n = held_flags_q;
		held_event_n = held_event_q;
		held_seq_n   = held_seq_q;
		held_has_n   = held_has_q;
		held_stale_n = held_stale_q;
		held_port_n  = held_port_q;
		do_obs    = 1'b0;
		do_fail   = 1'b0;
		obs_temp  = '0;
		obs_flags = fail_flags;
		obs_event = sss_pkg::EVENT_NONE;
		status    = sss_pkg::STATUS_IDLE;

		if (pending_q) begin
			held_port_n = d.read_result;
			unique case (d.read_result)
				sss_pkg::PORT_OK: begin
					if (!seq_stale) begin
						last_seq_n = seq_in;
					end
					have_seq_n = 1'b1;
					obs_flags = sss_pkg::map_status(d.sample_status | d.port_status);
					if (seq_stale) begin
						obs_flags[sss_pkg::FLAG_STALE] = 1'b1;
					end
					held_seq_n   = 32'(seq_in);
					held_has_n   = 1'b1;
					held_stale_n = seq_stale;
					obs_temp  = d.sample_temperature;
					obs_event = sss_pkg::EVENT_SAMPLE;
					do_obs    = 1'b1;
					status    = sss_pkg::STATUS_PROCESSED;
				end
				sss_pkg::PORT_BUSY, sss_pkg::PORT_NOT_READY: begin
					pend_cnt_n = cnt_inc;
					if (32'(cnt_inc) >= 32'(timeout_cfg_q)) begin
						do_fail   = 1'b1;
						obs_event = sss_pkg::EVENT_TIMEOUT;
						status    = sss_pkg::STATUS_TIMEOUT;
					end else begin
						status = sss_pkg::STATUS_PENDING;
					end
				end
				default: begin
					do_fail   = 1'b1;
					obs_event = sss_pkg::EVENT_PORT_FAILURE;
					status    = sss_pkg::STATUS_READ_FAILED;
				end
			endcase
		end else begin
			if (countdown_q != '0) begin
				countdown_n = countdown_dec;
			end
			if (request) begin
				held_port_n = d.request_result;
				if (d.request_result != sss_pkg::PORT_ERROR) begin
					pending_n  = 1'b1;
					pend_cnt_n = '0;
					status     = sss_pkg::STATUS_PENDING;
				end else begin
					do_fail   = 1'b1;
					obs_event = sss_pkg::EVENT_PORT_FAILURE;
					status    = sss_pkg::STATUS_REQUEST_FAILED;
				end
			end
		end

		if (do_fail) begin
			held_has_n   = 1'b0;
			held_stale_n = 1'b0;
			do_obs       = 1'b1;
		end
		// an observation closes the request and restarts the period
		if (do_obs) begin
			held_num_n   = obs_cnt_q;
			obs_cnt_n    = obs_cnt_q + 32'd1;
			held_temp_n  = obs_temp;
			held_flags_n = obs_flags;
			held_event_n = obs_event;
			pending_n    = 1'b0;
			pend_cnt_n   = '0;
			countdown_n  = CW'(period_cfg_q);
		end

		result.status_code          = status;
		result.observation_valid    = do_obs;
		result.observation_number   = held_num_n;
		result.observed_temperature = held_temp_n;
		result.domain_flags         = held_flags_n;
		result.obs_cause            = held_event_n;
		result.request_pending      = pending_n;
		result.pending_ticks        = 16'(pend_cnt_n);
		result.source_sequence_out  = held_seq_n;
		result.from_sample          = held_has_n;
		result.source_stale         = held_stale_n;
		result.last_port_result     = held_port_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg_q  <= sss_pkg::SAMPLE_PERIOD_RESET;
			timeout_cfg_q <= sss_pkg::PENDING_TIMEOUT_RESET;
			pending_q     <= 1'b0;
			pend_cnt_q    <= '0;
			countdown_q   <= '0;
			have_seq_q    <= 1'b0;
			last_seq_q    <= '0;
			obs_cnt_q     <= '0;
			held_num_q    <= '0;
			held_temp_q   <= '0;
			held_flags_q  <= '0;
			held_event_q  <= sss_pkg::EVENT_NONE;
			held_seq_q    <= '0;
			held_has_q    <= 1'b0;
			held_stale_q  <= 1'b0;
			held_port_q   <= sss_pkg::PORT_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sss_pkg::CFG_SAMPLE_PERIOD:   period_cfg_q  <= cfg_data;
					sss_pkg::CFG_PENDING_TIMEOUT: timeout_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				pending_q    <= pending_n;
				pend_cnt_q   <= pend_cnt_n;
				countdown_q  <= countdown_n;
				have_seq_q   <= have_seq_n;
				last_seq_q   <= last_seq_n;
				obs_cnt_q    <= obs_cnt_n;
				held_num_q   <= held_num_n;
				held_temp_q  <= held_temp_n;
				held_flags_q <= held_flags_n;
				held_event_q <= held_event_n;
				held_seq_q   <= held_seq_n;
				held_has_q   <= held_has_n;
				held_stale_q <= held_stale_n;
				held_port_q  <= held_port_n;
				out_valid_q  <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

endmodule

// ----- design/sss_checker.sv -----
// port-level checks of the sensor sample supervisor, bound to the top level
// depends on sss_pkg, the channel interfaces and the assertion macro header
`timescale 1ns / 1ps
`include "sensor_sample_supervisor_macros.svh"

module sss_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input sss_pkg::result_word_t out_word
);

	logic take;
	logic status_obs;
	logic obs_shown;
	logic req_closed;

	assign take = in_valid && in_ready;
	assign status_obs = (out_word.status_code == sss_pkg::STATUS_PROCESSED)
		|| (out_word.status_code == sss_pkg::STATUS_TIMEOUT)
		|| (out_word.status_code == sss_pkg::STATUS_READ_FAILED)
		|| (out_word.status_code == sss_pkg::STATUS_REQUEST_FAILED);
	assign obs_shown  = out_valid && out_word.observation_valid;
	assign req_closed = !out_word.request_pending && (out_word.pending_ticks == 16'd0);

	// a stalled word holds
	`SSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// an empty output register never holds off input
	`SSS_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// every taken word gives a result word next cycle
	`SSS_ASSERT_NEXT(a_word_gives_result, clk, arst_n, take, out_valid)

	// an observation closes the request
	`SSS_ASSERT_IMPLY(a_obs_closes, clk, arst_n, obs_shown, req_closed)

	// observation flag agrees with the status code
	`SSS_ASSERT_IMPLY(a_obs_status, clk, arst_n, out_valid, out_word.observation_valid == status_obs)

endmodule

bind sensor_sample_supervisor sss_checker u_sss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_in.valid),
	.in_ready  (sample_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_word  (result_out.payload)
);

// ----- verif/sensor_sample_supervisor_tb.sv -----
// self-checking testbench of the sensor sample supervisor
// needs sss_pkg, the channel interfaces in sss_channels.sv and the top level
`timescale 1ns / 1ps

module sensor_sample_supervisor_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASE_WORDS = 250;

	logic clk;
	logic arst_n;
	logic cfg_we;
	sss_pkg::cfg_index_t cfg_index;
	logic [sss_pkg::CFG_WIDTH-1:0] cfg_data;

	sss_in_if sample_in ();
	sss_out_if result_out ();

	sensor_sample_supervisor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.result_out (result_out)
	);

	// supervisor state as the testbench sees it
	logic [sss_pkg::CFG_WIDTH-1:0]   period_reg;
	logic [sss_pkg::CFG_WIDTH-1:0]   timeout_reg;
	logic                            pend;
	logic [sss_pkg::COUNT_WIDTH-1:0] pend_cnt;
	logic [sss_pkg::COUNT_WIDTH-1:0] countdown;
	logic                            seq_seen;
	logic [sss_pkg::SEQ_WIDTH-1:0]   seq_last;
	logic [31:0]                     obs_count;
	sss_pkg::result_word_t           held_view;

	sss_pkg::result_word_t expected_results[$];
	int  mismatches;
	int  cycles;
	bit  idling_on;
	logic [31:0] seq_cursor;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sensor_sample_supervisor regression: fail");
			$finish;
		end
	end

	function automatic logic [4:0] raw_to_flags(input logic [6:0] s);
		// overrun adds stale and fault, unknown adds fault
		return s[4:0] | {s[6] | s[5], 2'b00, s[5], 1'b0};
	endfunction

	function automatic void close_observation(input logic signed [15:0] t,
			input logic [4:0] f, input sss_pkg::event_t ev);
		held_view.observation_number = obs_count;
		obs_count = obs_count + 32'd1;
		held_view.observed_temperature = t;
		held_view.domain_flags = f;
		held_view.obs_cause = ev;
		pend = 1'b0;
		pend_cnt = '0;
		countdown = period_reg;
	endfunction

	function automatic void close_failure(input logic [6:0] ps, input sss_pkg::event_t ev);
		logic [4:0] f;
		f = raw_to_flags(ps);
		f[sss_pkg::FLAG_VALID] = 1'b0;
		f[sss_pkg::FLAG_STALE] = 1'b1;
		f[sss_pkg::FLAG_FAULT] = 1'b1;
		held_view.from_sample = 1'b0;
		held_view.source_stale = 1'b0;
		close_observation(16'sd0, f, ev);
	endfunction

	function automatic sss_pkg::result_word_t supervise_tick(input sss_pkg::sample_word_t w);
		sss_pkg::result_word_t r;
		logic stale;
		logic [4:0] f;
		logic [sss_pkg::SEQ_WIDTH-1:0] fwd;
		logic fire;
		sss_pkg::status_code_t st;
		logic obs;
		st = sss_pkg::STATUS_IDLE;
		obs = 1'b0;
		if (pend) begin
			held_view.last_port_result = w.read_result;
			if (w.read_result == sss_pkg::PORT_OK) begin
				stale = 1'b0;
				if (!seq_seen) begin
					seq_seen = 1'b1;
					seq_last = w.sample_sequence;
				end else begin
					// forward distance must be non-zero and below half the range
					fwd = w.sample_sequence - seq_last;
					if (fwd == '0 || fwd[sss_pkg::SEQ_WIDTH-1]) begin
						stale = 1'b1;
					end else begin
						seq_last = w.sample_sequence;
					end
				end
				f = raw_to_flags(w.sample_status | w.port_status);
				if (stale) begin
					f[sss_pkg::FLAG_STALE] = 1'b1;
				end
				held_view.source_sequence_out = w.sample_sequence;
				held_view.from_sample = 1'b1;
				held_view.source_stale = stale;
				close_observation(w.sample_temperature, f, sss_pkg::EVENT_SAMPLE);
				st = sss_pkg::STATUS_PROCESSED;
				obs = 1'b1;
			end else if (w.read_result == sss_pkg::PORT_ERROR) begin
				close_failure(w.port_status, sss_pkg::EVENT_PORT_FAILURE);
				st = sss_pkg::STATUS_READ_FAILED;
				obs = 1'b1;
			end else begin
				if (pend_cnt != '1) begin
					pend_cnt = pend_cnt + 1'b1;
				end
				if (pend_cnt >= timeout_reg) begin
					close_failure(w.port_status, sss_pkg::EVENT_TIMEOUT);
					st = sss_pkg::STATUS_TIMEOUT;
					obs = 1'b1;
				end else begin
					st = sss_pkg::STATUS_PENDING;
				end
			end
		end else begin
			fire = 1'b1;
			if (countdown != '0) begin
				countdown = countdown - 1'b1;
				if (countdown != '0) begin
					fire = 1'b0;
				end
			end
			if (fire) begin
				held_view.last_port_result = w.request_result;
				if (w.request_result != sss_pkg::PORT_ERROR) begin
					pend = 1'b1;
					pend_cnt = '0;
					st = sss_pkg::STATUS_PENDING;
				end else begin
					close_failure(w.port_status, sss_pkg::EVENT_PORT_FAILURE);
					st = sss_pkg::STATUS_REQUEST_FAILED;
					obs = 1'b1;
				end
			end
		end
		r = held_view;
		r.status_code = st;
		r.observation_valid = obs;
		r.request_pending = pend;
		r.pending_ticks = pend_cnt;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	always @(posedge clk) begin : result_checker
		sss_pkg::result_word_t want;
		sss_pkg::result_word_t got;
		if (arst_n && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
			got = result_out.payload;
			if (expected_results.size() == 0) begin
				$display("%0t mismatch unexpected word: expected none actual %0h", $time, got);
				mismatches = mismatches + 1;
			end else begin
				want = expected_results.pop_front();
				check_field("status_code", 32'(want.status_code), 32'(got.status_code));
				check_field("observation_valid", 32'(want.observation_valid),
					32'(got.observation_valid));
				check_field("observation_number", want.observation_number,
					got.observation_number);
				check_field("observed_temperature", 32'(want.observed_temperature),
					32'(got.observed_temperature));
				check_field("domain_flags", 32'(want.domain_flags), 32'(got.domain_flags));
				check_field("obs_cause", 32'(want.obs_cause), 32'(got.obs_cause));
				check_field("request_pending", 32'(want.request_pending),
					32'(got.request_pending));
				check_field("pending_ticks", 32'(want.pending_ticks), 32'(got.pending_ticks));
				check_field("source_sequence_out", want.source_sequence_out,
					got.source_sequence_out);
				check_field("from_sample", 32'(want.from_sample), 32'(got.from_sample));
				check_field("source_stale", 32'(want.source_stale), 32'(got.source_stale));
				check_field("last_port_result", 32'(want.last_port_result),
					32'(got.last_port_result));
			end
		end
	end

	// result side: random stall before each word while idling is on
	initial begin : result_sink
		int stall;
		result_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idling_on ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				result_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_out.ready <= 1'b1;
			do @(posedge clk); while (result_out.valid !== 1'b1);
		end
	end

	function automatic sss_pkg::sample_word_t random_word();
		sss_pkg::sample_word_t w;
		w.request_result = 2'($urandom_range(0, 3));
		w.read_result = 2'($urandom_range(0, 3));
		w.sample_status = 7'($urandom_range(0, 127));
		w.port_status = 7'($urandom_range(0, 127));
		w.sample_sequence = $urandom;
		w.sample_temperature = 16'($urandom_range(0, 65535));
		return w;
	endfunction

	task automatic send_sample(input sss_pkg::sample_word_t w);
		int gap;
		gap = idling_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			sample_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_in.valid <= 1'b1;
		sample_in.payload <= w;
		do @(posedge clk); while (sample_in.ready !== 1'b1);
		expected_results.push_back(supervise_tick(w));
	endtask

	task automatic wait_for_results();
		sample_in.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input sss_pkg::cfg_index_t idx,
			input logic [sss_pkg::CFG_WIDTH-1:0] v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sss_pkg::CFG_SAMPLE_PERIOD) begin
			period_reg = v;
		end else begin
			timeout_reg = v;
		end
	endtask

	// close any open request and run the countdown down so the next word requests
	task automatic bring_to_request();
		sss_pkg::sample_word_t w;
		while (pend || countdown > 1) begin
			w = random_word();
			w.read_result = sss_pkg::PORT_ERROR;
			send_sample(w);
		end
	endtask

	task automatic sample_read(input logic [31:0] seq, input logic [6:0] sstat,
			input logic [6:0] pstat, input logic signed [15:0] temp);
		sss_pkg::sample_word_t w;
		bring_to_request();
		w = random_word();
		w.request_result = sss_pkg::PORT_OK;
		send_sample(w);
		w = random_word();
		w.read_result = sss_pkg::PORT_OK;
		w.sample_status = sstat;
		w.port_status = pstat;
		w.sample_sequence = seq;
		w.sample_temperature = temp;
		send_sample(w);
	endtask

	// settings out of reset: first word requests, timeout 10, period 100
	task automatic test_reset_settings();
		sss_pkg::sample_word_t w;
		w = random_word();
		w.request_result = sss_pkg::PORT_OK;
		send_sample(w);
		repeat (10) begin
			w = random_word();
			w.read_result = sss_pkg::PORT_BUSY;
			send_sample(w);
		end
		repeat (100) send_sample(random_word());
	endtask

	task automatic test_status_mapping();
		sss_pkg::sample_word_t w;
		write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd0);
		write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd3);
		sample_read(32'd5, 7'h20, 7'h00, -16'sd32768);
		sample_read(32'd6, 7'h40, 7'h01, 16'sd32767);
		sample_read(32'd7, 7'h1F, 7'h60, 16'sd0);
		sample_read(32'd7, 7'h00, 7'h00, -16'sd1);
		// busy request still opens a request, then read error
		bring_to_request();
		w = random_word();
		w.request_result = sss_pkg::PORT_BUSY;
		send_sample(w);
		w = random_word();
		w.read_result = sss_pkg::PORT_NOT_READY;
		send_sample(w);
		w = random_word();
		w.read_result = sss_pkg::PORT_ERROR;
		w.port_status = 7'h7F;
		send_sample(w);
		w = random_word();
		w.request_result = sss_pkg::PORT_ERROR;
		w.port_status = 7'h21;
		send_sample(w);
		w = random_word();
		w.request_result = sss_pkg::PORT_NOT_READY;
		send_sample(w);
		repeat (3) begin
			w = random_word();
			w.read_result = sss_pkg::PORT_BUSY;
			send_sample(w);
		end
	endtask

	task automatic test_sequence_order();
		write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd1);
		sample_read(32'hFFFF_FFFF, 7'h01, 7'h00, 16'sd100);
		sample_read(32'h0000_0000, 7'h01, 7'h00, 16'sd101);
		sample_read(32'h8000_0000, 7'h01, 7'h00, 16'sd102);
		sample_read(32'h7FFF_FFFF, 7'h01, 7'h00, 16'sd103);
		sample_read(32'h7FFF_FFFE, 7'h01, 7'h00, 16'sd104);
		sample_read(32'hFFFF_FFFF, 7'h01, 7'h00, 16'sd105);
	endtask

	// zero timeout fails on the first busy word, zero period requests at once
	task automatic test_zero_settings();
		sss_pkg::sample_word_t w;
		write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd0);
		bring_to_request();
		w = random_word();
		w.request_result = sss_pkg::PORT_OK;
		send_sample(w);
		w = random_word();
		w.read_result = sss_pkg::PORT_NOT_READY;
		send_sample(w);
		w = random_word();
		w.request_result = sss_pkg::PORT_OK;
		send_sample(w);
		w = random_word();
		w.read_result = sss_pkg::PORT_BUSY;
		send_sample(w);
	endtask

	// widest timeout lets the pending count climb, then a long period runs down
	task automatic test_long_counts();
		sss_pkg::sample_word_t w;
		write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd300);
		write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'hFFFF);
		idling_on = 1'b0;
		bring_to_request();
		w = random_word();
		w.request_result = sss_pkg::PORT_OK;
		send_sample(w);
		repeat (200) begin
			w = random_word();
			w.read_result = 2'($urandom_range(sss_pkg::PORT_BUSY, sss_pkg::PORT_NOT_READY));
			send_sample(w);
		end
		w = random_word();
		w.read_result = sss_pkg::PORT_OK;
		send_sample(w);
		repeat (300) begin
			w = random_word();
			w.request_result = 2'($urandom_range(0, 2));
			send_sample(w);
		end
		w = random_word();
		w.read_result = sss_pkg::PORT_OK;
		send_sample(w);
		idling_on = 1'b1;
	endtask

	function automatic sss_pkg::sample_word_t traffic_word();
		sss_pkg::sample_word_t w;
		int pick;
		w = random_word();
		w.request_result = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 2))
			: sss_pkg::PORT_ERROR;
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			w.read_result = sss_pkg::PORT_OK;
		end else if (pick < 16) begin
			w.read_result = 2'($urandom_range(sss_pkg::PORT_BUSY, sss_pkg::PORT_NOT_READY));
		end else begin
			w.read_result = sss_pkg::PORT_ERROR;
		end
		if ($urandom_range(0, 3) == 0) begin
			w.sample_status = '0;
			w.port_status = '0;
		end
		pick = $urandom_range(0, 19);
		case (pick)
			0: begin
				seq_cursor = $urandom;
				w.sample_sequence = seq_cursor;
			end
			1: w.sample_sequence = seq_cursor;
			2: w.sample_sequence = seq_cursor - $urandom_range(1, 5);
			3: begin
				seq_cursor = 32'hFFFF_FFFF - $urandom_range(0, 3);
				w.sample_sequence = seq_cursor;
			end
			default: begin
				seq_cursor = seq_cursor + $urandom_range(1, 4);
				w.sample_sequence = seq_cursor;
			end
		endcase
		return w;
	endfunction

	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd1);
					write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd1);
				end
				1: begin
					write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd3);
					write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd6);
				end
				2: begin
					write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'($urandom_range(1, 8)));
					write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'($urandom_range(1, 12)));
				end
				3: begin
					write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd2);
					write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'hFFFF);
				end
				default: begin
					write_register(sss_pkg::CFG_SAMPLE_PERIOD, 16'd1);
					write_register(sss_pkg::CFG_PENDING_TIMEOUT, 16'd2);
					idling_on = 1'b0;
				end
			endcase
			for (n = 0; n < PHASE_WORDS; n++) begin
				// hold off mid-phase until the result side has caught up
				if (phase == 2 && n == PHASE_WORDS / 2) begin
					wait_for_results();
				end
				send_sample(traffic_word());
			end
		end
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sss_pkg::CFG_SAMPLE_PERIOD;
		cfg_data = '0;
		sample_in.valid = 1'b0;
		sample_in.payload = '0;
		mismatches = 0;
		cycles = 0;
		idling_on = 1'b1;
		seq_cursor = $urandom;
		period_reg = sss_pkg::SAMPLE_PERIOD_RESET;
		timeout_reg = sss_pkg::PENDING_TIMEOUT_RESET;
		pend = 1'b0;
		pend_cnt = '0;
		countdown = '0;
		seq_seen = 1'b0;
		seq_last = '0;
		obs_count = '0;
		held_view = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_status_mapping();
		test_sequence_order();
		test_zero_settings();
		test_long_counts();
		test_random_traffic();

		wait_for_results();
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("sensor_sample_supervisor regression: pass");
		end else begin
			$display("sensor_sample_supervisor regression: fail");
		end
		$finish;
	end

endmodule
